>>> src/tss_pkg.sv
// ----------------------------------------------------------------------------
// Track shuttle sequencer package
// Shared widths, codes, reset values and payload types of the sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 10;
  localparam int SEQ_BITS    = 16;
  localparam int SPEED_BITS  = 8;
  localparam int CFG_BITS    = (SAMPLE_BITS > SPEED_BITS) ? SAMPLE_BITS : SPEED_BITS;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_NORTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_SOUTH     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REFERENCE_NORTH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REFERENCE_SOUTH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OCCUPANCY_MARGIN = 3'd4;

  // Configuration reset values.
  localparam logic [SPEED_BITS-1:0]  SPEED_RESET  = SPEED_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] MARGIN_RESET = SAMPLE_BITS'(120);

  // Command codes of an input item.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Sequencer modes.
  typedef enum logic [3:0] {
    MODE_SELFTEST  = 4'd0,
    MODE_IDLE      = 4'd1,
    MODE_BEGIN     = 4'd2,
    MODE_THROW     = 4'd3,
    MODE_THROWN    = 4'd4,
    MODE_START     = 4'd5,
    MODE_DEPART    = 4'd6,
    MODE_ARRIVE    = 4'd7,
    MODE_STOPTRAIN = 4'd8,
    MODE_FINISH    = 4'd9,
    MODE_EMERGENCY = 4'd10,
    MODE_STOPPED   = 4'd11,
    MODE_RESET     = 4'd12
  } mode_t;

  // Trip directions.
  typedef enum logic [2:0] {
    DIR_NONE = 3'd0,
    DIR_NW   = 3'd1,
    DIR_NE   = 3'd2,
    DIR_SW   = 3'd3,
    DIR_SE   = 3'd4
  } dir_t;

  // User request kinds.
  localparam logic [2:0] REQ_NONE    = 3'd0;
  localparam logic [2:0] REQ_NW      = 3'd1;
  localparam logic [2:0] REQ_NE      = 3'd2;
  localparam logic [2:0] REQ_SW      = 3'd3;
  localparam logic [2:0] REQ_SE      = 3'd4;
  localparam logic [2:0] REQ_STOP    = 3'd5;
  localparam logic [2:0] REQ_RESET   = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  // Switch pulse codes.
  localparam logic [1:0] PULSE_NONE  = 2'd0;
  localparam logic [1:0] PULSE_NORTH = 2'd1;
  localparam logic [1:0] PULSE_SOUTH = 2'd2;

  // Input item.
  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample_north;
    logic [SAMPLE_BITS-1:0] sample_south;
    logic [2:0]             request_kind;
    logic [SEQ_BITS-1:0]    request_sequence;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [3:0]            mode;
    logic [2:0]            trip_direction;
    logic [SPEED_BITS-1:0] drive_east;
    logic [SPEED_BITS-1:0] drive_west;
    logic [1:0]            switch_pulse;
    logic                  north_occupied;
    logic                  south_occupied;
  } out_item_t;

endpackage

>>> src/track_shuttle_sequencer.sv
// ----------------------------------------------------------------------------
// Track shuttle sequencer
// Single-step control sequencer for a two-track shuttle with occupancy sensing.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_data. A tick item carries one light
//   sensor sample per track and advances the trip sequence by one step; a
//   request item may change the mode when its sequence number is new.
//   Every accepted item produces exactly one result on out_valid/out_data,
//   holding mode, direction, drive levels, switch pulse and occupancy.
//   A result appears in the cycle after its transfer.
//   Throughput is one item per cycle; the only loop is the single-step
//   update of the sequencer state, closed through one register stage.
//   The result register is released in the same cycle it is taken, so the
//   input stalls only while a result is held by out_stall.
//   Configuration writes on cfg_we/cfg_index/cfg_data take effect at once;
//   the user must issue them only while no item is in flight (not enforced).
//   Synchronous reset returns the sequencer to self-test with no direction,
//   zero drive, zero sequence number and default configuration, and drops
//   any pending result.
// ----------------------------------------------------------------------------
module track_shuttle_sequencer
  import tss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  // Configuration port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  // Configuration registers.
  logic [SPEED_BITS-1:0]  speed_north_r;
  logic [SPEED_BITS-1:0]  speed_south_r;
  logic [SAMPLE_BITS-1:0] reference_north_r;
  logic [SAMPLE_BITS-1:0] reference_south_r;
  logic [SAMPLE_BITS-1:0] margin_r;

  // Sequencer state.
  mode_t                  mode_r, mode_nxt;
  dir_t                   dir_r, dir_nxt;
  logic [SEQ_BITS-1:0]    last_seq_r, last_seq_nxt;
  logic [SPEED_BITS-1:0]  east_r, east_nxt;
  logic [SPEED_BITS-1:0]  west_r, west_nxt;
  logic [SAMPLE_BITS-1:0] latest_north_r, latest_north_nxt;
  logic [SAMPLE_BITS-1:0] latest_south_r, latest_south_nxt;

  // Result register.
  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;

  logic                   accept;
  logic [1:0]             pulse;
  logic                   occ_north, occ_south;
  logic                   dir_north, dir_south;
  logic [SPEED_BITS-1:0]  speed;
  logic [SAMPLE_BITS:0]   limit_north, limit_south;

  // The result register frees up whenever its content is taken.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_north_r     <= SPEED_RESET;
      speed_south_r     <= SPEED_RESET;
      reference_north_r <= '0;
      reference_south_r <= '0;
      margin_r          <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_NORTH:      speed_north_r     <= cfg_data[SPEED_BITS-1:0];
        CFG_SPEED_SOUTH:      speed_south_r     <= cfg_data[SPEED_BITS-1:0];
        CFG_REFERENCE_NORTH:  reference_north_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_REFERENCE_SOUTH:  reference_south_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_OCCUPANCY_MARGIN: margin_r          <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Latest samples: a tick replaces them before the step is evaluated.
  always_comb begin
    latest_north_nxt = latest_north_r;
    latest_south_nxt = latest_south_r;
    if (in_data.command == CMD_TICK) begin
      latest_north_nxt = in_data.sample_north;
      latest_south_nxt = in_data.sample_south;
    end
  end

  // Occupancy compares against reference plus margin, one bit wider.
  assign limit_north = {1'b0, reference_north_r} + {1'b0, margin_r};
  assign limit_south = {1'b0, reference_south_r} + {1'b0, margin_r};
  assign occ_north   = {1'b0, latest_north_nxt} < limit_north;
  assign occ_south   = {1'b0, latest_south_nxt} < limit_south;

  assign dir_north = (dir_r == DIR_NW) || (dir_r == DIR_NE);
  assign dir_south = (dir_r == DIR_SW) || (dir_r == DIR_SE);
  assign speed     = dir_north ? speed_north_r : (dir_south ? speed_south_r : '0);

  // One step of the sequencer for a tick or a request.
  always_comb begin
    mode_nxt     = mode_r;
    dir_nxt      = dir_r;
    last_seq_nxt = last_seq_r;
    east_nxt     = east_r;
    west_nxt     = west_r;
    pulse        = PULSE_NONE;

    if (in_data.command == CMD_TICK) begin
      case (mode_r)
        MODE_SELFTEST: begin
          mode_nxt = (occ_north && occ_south) ? MODE_IDLE : MODE_EMERGENCY;
        end
        MODE_IDLE, MODE_STOPPED: ;
        MODE_BEGIN: begin
          mode_nxt = MODE_THROW;
        end
        MODE_THROW: begin
          if (dir_north) begin
            pulse    = PULSE_NORTH;
            mode_nxt = MODE_THROWN;
          end else if (dir_south) begin
            pulse    = PULSE_SOUTH;
            mode_nxt = MODE_THROWN;
          end else begin
            mode_nxt = MODE_EMERGENCY;
          end
        end
        MODE_THROWN: begin
          mode_nxt = MODE_START;
        end
        MODE_START: begin
          if ((dir_r == DIR_NE) || (dir_r == DIR_SE)) begin
            east_nxt = speed;
            west_nxt = '0;
            mode_nxt = MODE_DEPART;
          end else if ((dir_r == DIR_NW) || (dir_r == DIR_SW)) begin
            east_nxt = '0;
            west_nxt = speed;
            mode_nxt = MODE_DEPART;
          end else begin
            mode_nxt = MODE_EMERGENCY;
          end
        end
        MODE_DEPART: begin
          // The other track emptying overrides departure.
          if ((dir_north && !occ_south) || (dir_south && !occ_north)) begin
            mode_nxt = MODE_EMERGENCY;
          end else if ((dir_north && !occ_north) || (dir_south && !occ_south)) begin
            mode_nxt = MODE_ARRIVE;
          end
        end
        MODE_ARRIVE: begin
          if ((dir_north && !occ_south) || (dir_south && !occ_north)) begin
            mode_nxt = MODE_EMERGENCY;
          end else if ((dir_north && occ_north) || (dir_south && occ_south)) begin
            mode_nxt = MODE_STOPTRAIN;
          end
        end
        MODE_STOPTRAIN: begin
          east_nxt = '0;
          west_nxt = '0;
          mode_nxt = MODE_FINISH;
        end
        MODE_FINISH: begin
          mode_nxt = MODE_IDLE;
          dir_nxt  = DIR_NONE;
        end
        MODE_RESET: begin
          mode_nxt = MODE_SELFTEST;
          dir_nxt  = DIR_NONE;
        end
        default: begin
          // Emergency and the unused codes halt the train.
          east_nxt = '0;
          west_nxt = '0;
          mode_nxt = MODE_STOPPED;
          dir_nxt  = DIR_NONE;
        end
      endcase
    end else if (in_data.request_sequence != last_seq_r) begin
      last_seq_nxt = in_data.request_sequence;
      case (in_data.request_kind)
        REQ_NONE: ;
        REQ_NW, REQ_NE, REQ_SW, REQ_SE: begin
          if (mode_r == MODE_IDLE) begin
            dir_nxt  = dir_t'(in_data.request_kind);
            mode_nxt = MODE_BEGIN;
          end
        end
        REQ_STOP: begin
          dir_nxt = DIR_NONE;
          if (mode_r != MODE_STOPPED) begin
            mode_nxt = MODE_EMERGENCY;
          end
        end
        REQ_RESET: begin
          dir_nxt  = DIR_NONE;
          mode_nxt = (mode_r == MODE_STOPPED) ? MODE_SELFTEST : MODE_EMERGENCY;
        end
        default: begin
          dir_nxt  = DIR_NONE;
          mode_nxt = MODE_EMERGENCY;
        end
      endcase
    end
  end

  // Result of the step as seen after the update.
  always_comb begin
    out_data_nxt.mode           = mode_nxt;
    out_data_nxt.trip_direction = dir_nxt;
    out_data_nxt.drive_east     = east_nxt;
    out_data_nxt.drive_west     = west_nxt;
    out_data_nxt.switch_pulse   = pulse;
    out_data_nxt.north_occupied = occ_north;
    out_data_nxt.south_occupied = occ_south;
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_SELFTEST;
      dir_r          <= DIR_NONE;
      last_seq_r     <= '0;
      east_r         <= '0;
      west_r         <= '0;
      latest_north_r <= '0;
      latest_south_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        mode_r         <= mode_nxt;
        dir_r          <= dir_nxt;
        last_seq_r     <= last_seq_nxt;
        east_r         <= east_nxt;
        west_r         <= west_nxt;
        latest_north_r <= latest_north_nxt;
        latest_south_r <= latest_south_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/tss_checker.sv
// ----------------------------------------------------------------------------
// Track shuttle sequencer checker
// Port-level assertions on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input out_item_t               out_data
);

  // A stalled result stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every input transfer yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after input transfer");

  // A switch pulse is only issued when entering the thrown mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.switch_pulse != PULSE_NONE) |->
      (out_data.mode == MODE_THROWN))
    else $error("switch pulse outside switch throw");

  // Idle means no trip and no drive.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.mode == MODE_IDLE) |->
      (out_data.trip_direction == DIR_NONE) && (out_data.drive_east == '0) &&
      (out_data.drive_west == '0))
    else $error("idle with trip or drive active");

  // The input is only held off by a stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind track_shuttle_sequencer tss_checker u_tss_checker (.*);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Track shuttle sequencer testbench
// Drives tick and request transfers with random idle gaps and result stalls,
// predicts every status result in a scoreboard and compares field by field.
// The run covers several register settings, boundary samples and full trips.
// ----------------------------------------------------------------------------
module testbench;
  import tss_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int LONG_HOLD       = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 5;
  localparam int MAX_SAMPLE      = (1 << SAMPLE_BITS) - 1;
  localparam int MAX_GAP         = 11;
  localparam int MAX_MISMATCH_REPORTS = 10;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LOW  =
    CFG_OCCUPANCY_MARGIN + CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HIGH = '1;

  // Scoreboard: tracks the sequencer state and holds the expected status results.
  class shuttle_tracker;
    logic [SPEED_BITS-1:0]  speed_north;
    logic [SPEED_BITS-1:0]  speed_south;
    logic [SAMPLE_BITS-1:0] level_north;
    logic [SAMPLE_BITS-1:0] level_south;
    logic [SAMPLE_BITS-1:0] margin;
    mode_t                  mode;
    dir_t                   direction;
    logic [SEQ_BITS-1:0]    last_seq;
    logic [SPEED_BITS-1:0]  east_level;
    logic [SPEED_BITS-1:0]  west_level;
    logic [SAMPLE_BITS-1:0] latest_north;
    logic [SAMPLE_BITS-1:0] latest_south;
    out_item_t              expected_status[$];
    int                     failures;

    function new();
      speed_north  = SPEED_RESET;
      speed_south  = SPEED_RESET;
      level_north  = '0;
      level_south  = '0;
      margin       = MARGIN_RESET;
      mode         = MODE_SELFTEST;
      direction    = DIR_NONE;
      last_seq     = '0;
      east_level   = '0;
      west_level   = '0;
      latest_north = '0;
      latest_south = '0;
      failures     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] data);
      case (index)
        CFG_SPEED_NORTH:      speed_north = data[SPEED_BITS-1:0];
        CFG_SPEED_SOUTH:      speed_south = data[SPEED_BITS-1:0];
        CFG_REFERENCE_NORTH:  level_north = data[SAMPLE_BITS-1:0];
        CFG_REFERENCE_SOUTH:  level_south = data[SAMPLE_BITS-1:0];
        CFG_OCCUPANCY_MARGIN: margin      = data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Reference plus margin, one bit wider so that the sum cannot wrap.
    function logic [SAMPLE_BITS:0] bound(logic [SAMPLE_BITS-1:0] level);
      return {1'b0, level} + {1'b0, margin};
    endfunction

    function bit north_occupied();
      return {1'b0, latest_north} < bound(level_north);
    endfunction

    function bit south_occupied();
      return {1'b0, latest_south} < bound(level_south);
    endfunction

    // One sequencer step on a tick; returns the switch pulse of this step.
    function logic [1:0] step_tick();
      logic [1:0]            pulse;
      logic [SPEED_BITS-1:0] speed;
      bit                    n;
      bit                    s;
      bit                    on;
      bit                    os;
      pulse = PULSE_NONE;
      n  = (direction == DIR_NW) || (direction == DIR_NE);
      s  = (direction == DIR_SW) || (direction == DIR_SE);
      on = north_occupied();
      os = south_occupied();
      case (mode)
        MODE_SELFTEST: mode = (on && os) ? MODE_IDLE : MODE_EMERGENCY;
        MODE_IDLE, MODE_STOPPED: ;
        MODE_BEGIN: mode = MODE_THROW;
        MODE_THROW: begin
          if (n) begin
            pulse = PULSE_NORTH;
            mode  = MODE_THROWN;
          end else if (s) begin
            pulse = PULSE_SOUTH;
            mode  = MODE_THROWN;
          end else begin
            mode = MODE_EMERGENCY;
          end
        end
        MODE_THROWN: mode = MODE_START;
        MODE_START: begin
          speed = n ? speed_north : (s ? speed_south : '0);
          if (direction == DIR_NE || direction == DIR_SE) begin
            east_level = speed;
            west_level = '0;
            mode       = MODE_DEPART;
          end else if (direction == DIR_NW || direction == DIR_SW) begin
            east_level = '0;
            west_level = speed;
            mode       = MODE_DEPART;
          end else begin
            mode = MODE_EMERGENCY;
          end
        end
        MODE_DEPART: begin
          if ((n && !on) || (s && !os)) mode = MODE_ARRIVE;
          if ((n && !os) || (s && !on)) mode = MODE_EMERGENCY;
        end
        MODE_ARRIVE: begin
          if ((n && on) || (s && os)) mode = MODE_STOPTRAIN;
          if ((n && !os) || (s && !on)) mode = MODE_EMERGENCY;
        end
        MODE_STOPTRAIN: begin
          east_level = '0;
          west_level = '0;
          mode       = MODE_FINISH;
        end
        MODE_FINISH: begin
          mode      = MODE_IDLE;
          direction = DIR_NONE;
        end
        MODE_RESET: begin
          mode      = MODE_SELFTEST;
          direction = DIR_NONE;
        end
        default: begin
          east_level = '0;
          west_level = '0;
          mode       = MODE_STOPPED;
          direction  = DIR_NONE;
        end
      endcase
      return pulse;
    endfunction

    // A request only counts when its sequence number is new.
    function void apply_request(logic [2:0] kind, logic [SEQ_BITS-1:0] seq);
      if (seq == last_seq) return;
      case (kind)
        REQ_NONE: ;
        REQ_NW, REQ_NE, REQ_SW, REQ_SE: begin
          if (mode == MODE_IDLE) begin
            direction = dir_t'(kind);
            mode      = MODE_BEGIN;
          end
        end
        REQ_STOP: begin
          direction = DIR_NONE;
          if (mode != MODE_STOPPED) mode = MODE_EMERGENCY;
        end
        REQ_RESET: begin
          direction = DIR_NONE;
          mode      = (mode == MODE_STOPPED) ? MODE_SELFTEST : MODE_EMERGENCY;
        end
        default: begin
          direction = DIR_NONE;
          mode      = MODE_EMERGENCY;
        end
      endcase
      last_seq = seq;
    endfunction

    // Called for every accepted input transfer.
    function void note_transfer(in_item_t item);
      out_item_t  status;
      logic [1:0] pulse;
      pulse = PULSE_NONE;
      if (item.command == CMD_TICK) begin
        latest_north = item.sample_north;
        latest_south = item.sample_south;
        pulse = step_tick();
      end else begin
        apply_request(item.request_kind, item.request_sequence);
      end
      status.mode           = mode;
      status.trip_direction = direction;
      status.drive_east     = east_level;
      status.drive_west     = west_level;
      status.switch_pulse   = pulse;
      status.north_occupied = north_occupied();
      status.south_occupied = south_occupied();
      expected_status.push_back(status);
    endfunction

    // Called for every accepted result transfer.
    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= MAX_MISMATCH_REPORTS)
          $display("%0t: result with no pending expectation: %h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      if (got.mode !== want.mode || got.trip_direction !== want.trip_direction ||
          got.drive_east !== want.drive_east || got.drive_west !== want.drive_west ||
          got.switch_pulse !== want.switch_pulse ||
          got.north_occupied !== want.north_occupied ||
          got.south_occupied !== want.south_occupied) begin
        failures++;
        if (failures <= MAX_MISMATCH_REPORTS)
          $display({"%0t: status mismatch (expected/actual): mode %0d/%0d dir %0d/%0d ",
                    "east %0d/%0d west %0d/%0d pulse %0d/%0d occ %b%b/%b%b"},
                   $time, want.mode, got.mode, want.trip_direction, got.trip_direction,
                   want.drive_east, got.drive_east, want.drive_west, got.drive_west,
                   want.switch_pulse, got.switch_pulse,
                   want.north_occupied, want.south_occupied,
                   got.north_occupied, got.south_occupied);
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  in_item_t                in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data  = '0;

  shuttle_tracker tracker = new();
  bit quiet        = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles  = 0;

  always #HALF_PERIOD clk = ~clk;

  track_shuttle_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_status(out_data);
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Result side: random stalls per result, plus one long hold-off on request.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = hold_request ? LONG_HOLD : draw_gap();
      hold_request = 1'b0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t make_tick(logic [SAMPLE_BITS-1:0] north,
                                         logic [SAMPLE_BITS-1:0] south);
    in_item_t item;
    item.command          = CMD_TICK;
    item.sample_north     = north;
    item.sample_south     = south;
    item.request_kind     = 3'($urandom);
    item.request_sequence = SEQ_BITS'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_request(logic [2:0] kind, logic [SEQ_BITS-1:0] seq);
    in_item_t item;
    item.command          = CMD_REQUEST;
    item.sample_north     = SAMPLE_BITS'($urandom);
    item.sample_south     = SAMPLE_BITS'($urandom);
    item.request_kind     = kind;
    item.request_sequence = seq;
    return item;
  endfunction

  // Pick a sample that makes a track occupied or empty, often right at the edge.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(bit want_occupied,
                                                          logic [SAMPLE_BITS-1:0] level);
    int limit;
    int lo;
    int hi;
    int pick;
    limit = int'(tracker.bound(level));
    pick  = $urandom_range(0, 7);
    if (want_occupied && limit > 0) begin
      lo = 0;
      hi = (limit > MAX_SAMPLE) ? MAX_SAMPLE : limit - 1;
    end else if (!want_occupied && limit <= MAX_SAMPLE) begin
      lo = limit;
      hi = MAX_SAMPLE;
    end else begin
      return SAMPLE_BITS'($urandom);
    end
    case (pick)
      0:       return SAMPLE_BITS'(lo);
      1:       return SAMPLE_BITS'(hi);
      2:       return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [SEQ_BITS-1:0] fresh_sequence();
    logic [SEQ_BITS-1:0] seq;
    seq = SEQ_BITS'($urandom);
    if (seq == tracker.last_seq) seq = seq + 1'b1;
    return seq;
  endfunction

  // Mostly steer the sequencer through whole trips, otherwise send noise.
  function automatic in_item_t next_item();
    bit north_trip;
    north_trip = (tracker.direction == DIR_NW) || (tracker.direction == DIR_NE);
    if ($urandom_range(0, 99) < 80) begin
      case (tracker.mode)
        MODE_IDLE: begin
          if ($urandom_range(0, 9) < 7)
            return make_request(3'($urandom_range(REQ_NW, REQ_SE)), fresh_sequence());
        end
        MODE_STOPPED: return make_request(REQ_RESET, fresh_sequence());
        MODE_DEPART: begin
          // The train leaves its own track while the other one stays occupied.
          if ($urandom_range(0, 9) < 8)
            return make_tick(pick_sample(!north_trip, tracker.level_north),
                             pick_sample(north_trip, tracker.level_south));
        end
        default: ;
      endcase
      return make_tick(pick_sample(1'b1, tracker.level_north),
                       pick_sample(1'b1, tracker.level_south));
    end
    if ($urandom_range(0, 1))
      return make_tick(pick_sample(1'($urandom_range(0, 1)), tracker.level_north),
                       pick_sample(1'($urandom_range(0, 1)), tracker.level_south));
    return make_request(3'($urandom_range(REQ_NONE, REQ_UNKNOWN)),
                        ($urandom_range(0, 3) == 0) ? tracker.last_seq : fresh_sequence());
  endfunction

  // Offer one input transfer after a random gap and wait until it is taken.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tracker.note_transfer(item);
  endtask

  // Write all registers for one phase, then one index beyond the list.
  task automatic write_settings(input int phase);
    logic [CFG_IDX_BITS-1:0] regs[5];
    logic [CFG_BITS-1:0]     values[5];
    logic [CFG_BITS-1:0]     data;
    regs = '{CFG_SPEED_NORTH, CFG_SPEED_SOUTH, CFG_REFERENCE_NORTH,
             CFG_REFERENCE_SOUTH, CFG_OCCUPANCY_MARGIN};
    case (phase)
      0:       values = '{100, 100, 300, 500, 120};
      1:       values = '{0, 255, 1023, 1023, 1023};
      2:       values = '{255, 0, 700, 1023, 0};
      3:       values = '{1, 254, 0, 0, 600};
      default: values = '{200, 37, 512, 80, 64};
    endcase
    for (int i = 0; i < 5; i++) begin
      data = values[i];
      // Speed registers are narrower than the port; the upper bits must be dropped.
      if (regs[i] == CFG_SPEED_NORTH || regs[i] == CFG_SPEED_SOUTH)
        data[CFG_BITS-1:SPEED_BITS] = (CFG_BITS-SPEED_BITS)'($urandom);
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= data;
      tracker.write_reg(regs[i], data);
    end
    data = CFG_BITS'($urandom);
    @(posedge clk);
    cfg_index <= CFG_IDX_BITS'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_HIGH));
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main stimulus.
  initial begin
    in_item_t opening[$];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // Withdraw the last item so it is not taken again while draining.
        in_valid <= 1'b0;
        while (tracker.expected_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      write_settings(phase);
      if (phase == 0) begin
        // North occupied below 420, south below 620.
        opening.push_back(make_tick(0, 619));
        opening.push_back(make_request(REQ_NE, 0));
        opening.push_back(make_request(REQ_NONE, 1));
        opening.push_back(make_request(REQ_NE, '1));
        opening.push_back(make_request(REQ_SW, 2));
        opening.push_back(make_tick(419, 0));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_tick(420, 0));
        opening.push_back(make_tick(419, 619));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_request(REQ_SW, 3));
        repeat (4) opening.push_back(make_tick(0, 0));
        // South empties as expected, but north empties too: emergency stop.
        opening.push_back(make_tick('1, 620));
        opening.push_back(make_tick(0, 0));
        opening.push_back(make_request(REQ_STOP, 4));
        opening.push_back(make_request(REQ_RESET, 5));
        opening.push_back(make_request(REQ_STOP, 6));
        opening.push_back(make_request(REQ_UNKNOWN, 7));
        opening.push_back(make_request(REQ_RESET, 8));
        foreach (opening[i]) send_item(opening[i]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Hold results back for a long stretch while input items keep being offered.
        if (n == 60) begin
          hold_request = 1'b1;
          quiet        = 1'b1;
        end
        send_item(next_item());
      end
    end
    in_valid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tss_pkg.sv
src/track_shuttle_sequencer.sv
src/tss_checker.sv
test/testbench.sv
